// ===== sv/stc_pkg.sv =====
// ----------------------------------------------------------------------------
// stc_pkg
// Shared widths, channel constants and control types of the stick axis
// to channel pipeline.
// ----------------------------------------------------------------------------
package stc_pkg;

	// field widths
	localparam int ADC_W      = 14;             // x4 smoothed reading
	localparam int RD_W       = ADC_W - 1;      // converter-scale reading, cal points
	localparam int CH_W       = 11;             // channel value
	localparam int BV_W       = CH_W + 1;       // branch value before final clamp
	localparam int TRIM_W     = 7;
	localparam int E_W        = 7;              // expo percent
	localparam int TSUM_W     = BV_W + 2;       // value plus trim, signed
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = RD_W;

	// map and divider
	localparam int PROD_W = 22;                 // distance * half range
	localparam int REM_W  = PROD_W + 1;
	localparam int Q_W    = 10;                 // quotient bits kept, saturates above

	// expo datapath
	localparam int A_W    = 9;                  // |value - mid|
	localparam int A2_W   = 2 * A_W;
	localparam int EA_W   = E_W + A_W;
	localparam int P_W    = EA_W + A2_W;        // e * |x|^3
	localparam int PD_W   = P_W - 6;            // after the power-of-two part of the divisor
	localparam int EP_W   = PD_W + 14;
	localparam int LP_W   = EA_W + 17;
	localparam int QC_W   = 10;
	localparam int T_W    = QC_W + 19;
	localparam int Z_W    = CH_W + 2;

	localparam logic [CH_W-1:0] CH_MID    = 11'd1500;
	localparam logic [CH_W-1:0] CH_LOW    = 11'd1000;
	localparam logic [CH_W-1:0] CH_HIGH   = 11'd2000;
	localparam logic [BV_W-1:0] CH_MIRROR = 12'd3000;
	localparam logic [8:0]      SPAN      = 9'd500;      // output half range
	localparam logic [Q_W-1:0]  Q_SAT     = '1;

	localparam logic [E_W-1:0]  EXPO_PCT    = 7'd100;
	localparam logic [16:0]     LIN_RECIP   = 17'd83887; // ceil(2^23 / 100)
	localparam int              LIN_SHIFT   = 23;
	localparam int              CUBE_PRE_SH = P_W - PD_W; // 25e6 = 2^6 * 390625
	localparam logic [18:0]     CUBE_DIV    = 19'd390625;
	localparam logic [13:0]     CUBE_RECIP  = 14'd10995; // floor(2^32 / 390625)
	localparam int              CUBE_SHIFT  = 32;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_CAL_MIN     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CAL_MAX     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CENTER_LOW  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CENTER_HIGH = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_INVERT      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_TRIM        = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_EXPO        = 3'd6;

	typedef enum logic [1:0] {
		BR_CENTER = 2'd0,
		BR_LOW    = 2'd1,
		BR_HIGH   = 2'd2
	} br_t;

	typedef struct packed {
		br_t  br;
		logic neg;   // span end below its band edge
		logic zero;  // zero-width span
	} map_ctl_t;

endpackage

// ===== sv/stc_front.sv =====
// ----------------------------------------------------------------------------
// stc_front
// Rounds the reading, picks the band branch and forms the map numerator
// and divisor magnitude. Stages s1 and s2.
// ----------------------------------------------------------------------------
module stc_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_vld,
	input  logic [stc_pkg::ADC_W-1:0]     adc_sum,
	input  logic [stc_pkg::RD_W-1:0]      cal_min,
	input  logic [stc_pkg::RD_W-1:0]      cal_max,
	input  logic [stc_pkg::RD_W-1:0]      center_low,
	input  logic [stc_pkg::RD_W-1:0]      center_high,
	output logic                          vld_s2,
	output stc_pkg::map_ctl_t             ctl_s2,
	output logic [stc_pkg::PROD_W-1:0]    prod_s2,
	output logic [stc_pkg::RD_W-1:0]      dabs_s2
);
	import stc_pkg::*;

	logic [ADC_W:0]    rsum;
	logic [RD_W-1:0]   rd;
	logic [RD_W:0]     span_d;
	logic [RD_W-1:0]   dgap;
	logic [RD_W-1:0]   dabs;
	map_ctl_t          ctl;
	logic [PROD_W-1:0] prod;

	logic              vld_s1;
	map_ctl_t          ctl_s1;
	logic [RD_W-1:0]   dgap_s1;
	logic [RD_W-1:0]   dabs_s1;

	always_comb begin
		rsum   = {1'b0, adc_sum} + (ADC_W + 1)'(2);
		rd     = rsum[ADC_W:2];
		ctl    = '{br: BR_CENTER, neg: 1'b0, zero: 1'b0};
		dgap   = '0;
		span_d = '0;
		if (rd < center_low) begin
			ctl.br = BR_LOW;
			dgap   = center_low - rd;
			span_d = {1'b0, cal_min} - {1'b0, center_low};
		end else if (rd > center_high) begin
			ctl.br = BR_HIGH;
			dgap   = rd - center_high;
			span_d = {1'b0, cal_max} - {1'b0, center_high};
		end
		ctl.neg  = span_d[RD_W];
		ctl.zero = (span_d == '0);
		dabs     = span_d[RD_W] ? RD_W'(-span_d) : span_d[RD_W-1:0];
	end

	assign prod = PROD_W'(dgap_s1) * PROD_W'(SPAN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s1  <= ctl;
			dgap_s1 <= dgap;
			dabs_s1 <= dabs;
			ctl_s2  <= ctl_s1;
			prod_s2 <= prod;
			dabs_s2 <= dabs_s1;
		end
	end

endmodule

// ===== sv/stc_div.sv =====
// ----------------------------------------------------------------------------
// stc_div
// Pipelined restoring divider, two quotient bits per stage. Quotients of
// 2^Q_W and more are flagged and saturate downstream. Stages s3 to s8.
// ----------------------------------------------------------------------------
module stc_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          vld_s2,
	input  stc_pkg::map_ctl_t             ctl_s2,
	input  logic [stc_pkg::PROD_W-1:0]    prod_s2,
	input  logic [stc_pkg::RD_W-1:0]      dabs_s2,
	output logic                          vld_s8,
	output stc_pkg::map_ctl_t             ctl_s8,
	output logic [stc_pkg::Q_W-1:0]       q_s8,
	output logic                          ovf_s8
);
	import stc_pkg::*;

	typedef struct packed {
		logic [REM_W-1:0] rem;
		logic             qb;
	} dstep_t;

	typedef struct packed {
		map_ctl_t         ctl;
		logic             ovf;
		logic [RD_W-1:0]  dv;
		logic [REM_W-1:0] rem;
		logic [Q_W-1:0]   q;
	} dstage_t;

	function automatic dstep_t div_step(input logic [REM_W-1:0] rem,
			input logic [RD_W-1:0] dv, input int unsigned sh);
		logic [REM_W-1:0] sub;
		dstep_t           r;
		sub = REM_W'(dv) << sh;
		if (rem >= sub) begin
			r.rem = rem - sub;
			r.qb  = 1'b1;
		end else begin
			r.rem = rem;
			r.qb  = 1'b0;
		end
		return r;
	endfunction

	function automatic dstage_t two_steps(input dstage_t st, input int unsigned sh);
		dstage_t o;
		dstep_t  a;
		dstep_t  b;
		o     = st;
		a     = div_step(st.rem, st.dv, sh + 1);
		b     = div_step(a.rem, st.dv, sh);
		o.rem = b.rem;
		o.q   = {st.q[Q_W-3:0], a.qb, b.qb};
		return o;
	endfunction

	dstage_t st_in;
	dstage_t st_s3, st_s4, st_s5, st_s6, st_s7, st_s8;
	logic    vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;

	always_comb begin
		st_in.ctl = ctl_s2;
		st_in.ovf = REM_W'(prod_s2) >= (REM_W'(dabs_s2) << Q_W);
		st_in.dv  = dabs_s2;
		st_in.rem = REM_W'(prod_s2);
		st_in.q   = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_s3 <= st_in;
			st_s4 <= two_steps(st_s3, Q_W - 2);
			st_s5 <= two_steps(st_s4, Q_W - 4);
			st_s6 <= two_steps(st_s5, Q_W - 6);
			st_s7 <= two_steps(st_s6, Q_W - 8);
			st_s8 <= two_steps(st_s7, Q_W - 10);
		end
	end

	assign ctl_s8 = st_s8.ctl;
	assign q_s8   = st_s8.q;
	assign ovf_s8 = st_s8.ovf;

endmodule

// ===== sv/stc_post.sv =====
// ----------------------------------------------------------------------------
// stc_post
// Builds the branch value with its end clamp, then inverts, trims and
// clamps to the channel range. Stages s9 and s10.
// ----------------------------------------------------------------------------
module stc_post (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                vld_s8,
	input  stc_pkg::map_ctl_t                   ctl_s8,
	input  logic [stc_pkg::Q_W-1:0]             q_s8,
	input  logic                                ovf_s8,
	input  logic                                invert,
	input  logic signed [stc_pkg::TRIM_W-1:0]   trim_offset,
	output logic                                vld_s10,
	output logic [stc_pkg::CH_W-1:0]            res_s10
);
	import stc_pkg::*;

	logic [Q_W-1:0]           qs;
	logic [BV_W-1:0]          pre;
	logic [BV_W-1:0]          bv;
	logic [BV_W-1:0]          iv;
	logic signed [TSUM_W-1:0] tsum;
	logic [CH_W-1:0]          res;

	logic                     vld_s9;
	logic [BV_W-1:0]          bv_s9;

	always_comb begin
		qs  = ovf_s8 ? Q_SAT : q_s8;
		pre = ctl_s8.neg ? BV_W'(CH_MID) - BV_W'(qs) : BV_W'(CH_MID) + BV_W'(qs);
		case (ctl_s8.br)
			BR_LOW: begin
				if (ctl_s8.zero || pre < BV_W'(CH_LOW))
					bv = BV_W'(CH_LOW);
				else
					bv = pre;
			end
			BR_HIGH: begin
				if (ctl_s8.zero || pre > BV_W'(CH_HIGH))
					bv = BV_W'(CH_HIGH);
				else
					bv = pre;
			end
			default: bv = BV_W'(CH_MID);
		endcase
	end

	always_comb begin
		iv   = invert ? CH_MIRROR - bv_s9 : bv_s9;
		tsum = signed'(TSUM_W'(iv)) + TSUM_W'(trim_offset);
		if (tsum < signed'(TSUM_W'(CH_LOW)))
			res = CH_LOW;
		else if (tsum > signed'(TSUM_W'(CH_HIGH)))
			res = CH_HIGH;
		else
			res = tsum[CH_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
		end else if (en) begin
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bv_s9   <= bv;
			res_s10 <= res;
		end
	end

endmodule

// ===== sv/stc_expo.sv =====
// ----------------------------------------------------------------------------
// stc_expo
// Cubic expo blend on sign and magnitude, constant divisions by reciprocal
// multiplication, final clamp. Stages s11 to s17.
// ----------------------------------------------------------------------------
module stc_expo (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          vld_s10,
	input  logic [stc_pkg::CH_W-1:0]      res_s10,
	input  logic [stc_pkg::E_W-1:0]       expo_percent,
	output logic                          vld_s17,
	output logic [stc_pkg::CH_W-1:0]      val_s17
);
	import stc_pkg::*;

	logic [BV_W-1:0]        xd;
	logic                   big;
	logic [P_W-1:0]         p;
	logic [LP_W-1:0]        lp;
	logic [EP_W-1:0]        ep;
	logic [T_W-1:0]         r;
	logic [Z_W-1:0]         cterm;
	logic [Z_W-1:0]         lterm;
	logic signed [Z_W-1:0]  z;
	logic [CH_W-1:0]        val;

	logic                   vld_s11, vld_s12, vld_s13, vld_s14, vld_s15, vld_s16;
	logic [A_W-1:0]         a_s11;
	logic [E_W-1:0]         ew_s11;
	logic                   sx_s11, sx_s12, sx_s13, sx_s14, sx_s15, sx_s16;
	logic                   sl_s11, sl_s12, sl_s13, sl_s14, sl_s15, sl_s16;
	logic [A2_W-1:0]        a2_s12;
	logic [EA_W-1:0]        ea_s12;
	logic [EA_W-1:0]        la_s12;
	logic [P_W-1:0]         p_s13;
	logic [QC_W-1:0]        ql_s13, ql_s14, ql_s15, ql_s16;
	logic [PD_W-1:0]        pd_s14, pd_s15;
	logic [QC_W-1:0]        est_s14, est_s15;
	logic [T_W-1:0]         t_s15;
	logic [QC_W-1:0]        qc_s16;

	// s11: signed offset from mid and linear weight
	always_comb begin
		xd  = {1'b0, res_s10} - {1'b0, CH_MID};
		big = expo_percent > EXPO_PCT;
	end

	assign p  = P_W'(ea_s12) * P_W'(a2_s12);
	assign lp = LP_W'(la_s12) * LP_W'(LIN_RECIP);
	assign ep = EP_W'(p_s13[P_W-1:CUBE_PRE_SH]) * EP_W'(CUBE_RECIP);
	assign r  = T_W'(pd_s15) - t_s15;

	// s17: signed sum of both terms around mid, then clamp
	always_comb begin
		cterm = sx_s16 ? Z_W'(0) - Z_W'(qc_s16) : Z_W'(qc_s16);
		lterm = sl_s16 ? Z_W'(0) - Z_W'(ql_s16) : Z_W'(ql_s16);
		z     = signed'(Z_W'(CH_MID) + cterm + lterm);
		if (z < signed'(Z_W'(CH_LOW)))
			val = CH_LOW;
		else if (z > signed'(Z_W'(CH_HIGH)))
			val = CH_HIGH;
		else
			val = z[CH_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s11 <= 1'b0;
			vld_s12 <= 1'b0;
			vld_s13 <= 1'b0;
			vld_s14 <= 1'b0;
			vld_s15 <= 1'b0;
			vld_s16 <= 1'b0;
			vld_s17 <= 1'b0;
		end else if (en) begin
			vld_s11 <= vld_s10;
			vld_s12 <= vld_s11;
			vld_s13 <= vld_s12;
			vld_s14 <= vld_s13;
			vld_s15 <= vld_s14;
			vld_s16 <= vld_s15;
			vld_s17 <= vld_s16;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s11   <= xd[BV_W-1] ? A_W'(-xd) : xd[A_W-1:0];
			sx_s11  <= xd[BV_W-1];
			sl_s11  <= xd[BV_W-1] ^ big;
			ew_s11  <= big ? expo_percent - EXPO_PCT : EXPO_PCT - expo_percent;

			a2_s12  <= A2_W'(a_s11) * A2_W'(a_s11);
			ea_s12  <= EA_W'(expo_percent) * EA_W'(a_s11);
			la_s12  <= EA_W'(ew_s11) * EA_W'(a_s11);
			sx_s12  <= sx_s11;
			sl_s12  <= sl_s11;

			p_s13   <= p;
			ql_s13  <= QC_W'(lp >> LIN_SHIFT);
			sx_s13  <= sx_s12;
			sl_s13  <= sl_s12;

			// estimate is exact or one short
			pd_s14  <= p_s13[P_W-1:CUBE_PRE_SH];
			est_s14 <= ep[CUBE_SHIFT+QC_W-1:CUBE_SHIFT];
			ql_s14  <= ql_s13;
			sx_s14  <= sx_s13;
			sl_s14  <= sl_s13;

			t_s15   <= T_W'(est_s14) * T_W'(CUBE_DIV);
			pd_s15  <= pd_s14;
			est_s15 <= est_s14;
			ql_s15  <= ql_s14;
			sx_s15  <= sx_s14;
			sl_s15  <= sl_s14;

			qc_s16  <= (r >= T_W'(CUBE_DIV)) ? est_s15 + QC_W'(1) : est_s15;
			ql_s16  <= ql_s15;
			sx_s16  <= sx_s15;
			sl_s16  <= sl_s15;

			val_s17 <= val;
		end
	end

endmodule

// ===== sv/stick_axis_to_channel.sv =====
// ----------------------------------------------------------------------------
// stick_axis_to_channel - stick reading to RC channel value, one axis
// Throughput: one word per cycle while the skid slot is empty; 17 register stages,
// set by the 10-bit restoring divider (two bits a stage) and the expo multiply chain.
// Reset: arst_n clears all valid bits and the skid slot, restores cal regs.
// ----------------------------------------------------------------------------
module stick_axis_to_channel (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [stc_pkg::ADC_W-1:0]         adc_sum,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [stc_pkg::CH_W-1:0]          channel_value,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [stc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [stc_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import stc_pkg::*;

	// calibration and shaping registers
	logic [RD_W-1:0]          cal_min_q;
	logic [RD_W-1:0]          cal_max_q;
	logic [RD_W-1:0]          center_low_q;
	logic [RD_W-1:0]          center_high_q;
	logic                     invert_q;
	logic signed [TRIM_W-1:0] trim_q;
	logic [E_W-1:0]           expo_q;

	// pipeline links
	logic                     en;
	logic                     vld_s2;
	map_ctl_t                 ctl_s2;
	logic [PROD_W-1:0]        prod_s2;
	logic [RD_W-1:0]          dabs_s2;
	logic                     vld_s8;
	map_ctl_t                 ctl_s8;
	logic [Q_W-1:0]           q_s8;
	logic                     ovf_s8;
	logic                     vld_s10;
	logic [CH_W-1:0]          res_s10;
	logic                     vld_s17;
	logic [CH_W-1:0]          val_s17;

	// output skid slot
	logic                     skid_vld_q;
	logic [CH_W-1:0]          skid_q;

	// Config writes are always taken; the user must keep the block idle whenever they come, it does not enforce this.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_min_q     <= 13'd0;
			cal_max_q     <= 13'd4096;
			center_low_q  <= 13'd1848;
			center_high_q <= 13'd2248;
			invert_q      <= 1'b0;
			trim_q        <= '0;
			expo_q        <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_CAL_MIN:     cal_min_q     <= cfg_data[RD_W-1:0];
				CFG_CAL_MAX:     cal_max_q     <= cfg_data[RD_W-1:0];
				CFG_CENTER_LOW:  center_low_q  <= cfg_data[RD_W-1:0];
				CFG_CENTER_HIGH: center_high_q <= cfg_data[RD_W-1:0];
				CFG_INVERT:      invert_q      <= cfg_data[0];
				CFG_TRIM:        trim_q        <= signed'(cfg_data[TRIM_W-1:0]);
				CFG_EXPO:        expo_q        <= cfg_data[E_W-1:0];
				default: ;
			endcase
		end
	end

	// The whole pipe moves as one while the skid slot is empty. A word
	// that reaches the last stage while the sink stalls drops into the
	// slot, so one more word gets in before the input backs off. While
	// the slot is full every stage holds, valid bits included.
	assign en       = !skid_vld_q;
	assign in_ready = en;

	// s1..s2: round, band select, numerator and divisor magnitude
	stc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.in_vld      (in_valid),
		.adc_sum     (adc_sum),
		.cal_min     (cal_min_q),
		.cal_max     (cal_max_q),
		.center_low  (center_low_q),
		.center_high (center_high_q),
		.vld_s2      (vld_s2),
		.ctl_s2      (ctl_s2),
		.prod_s2     (prod_s2),
		.dabs_s2     (dabs_s2)
	);

	// s3..s8: map quotient, saturating flag for oversized results
	stc_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld_s2  (vld_s2),
		.ctl_s2  (ctl_s2),
		.prod_s2 (prod_s2),
		.dabs_s2 (dabs_s2),
		.vld_s8  (vld_s8),
		.ctl_s8  (ctl_s8),
		.q_s8    (q_s8),
		.ovf_s8  (ovf_s8)
	);

	// s9..s10: branch value, mirror, trim, channel clamp
	stc_post u_post (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.vld_s8      (vld_s8),
		.ctl_s8      (ctl_s8),
		.q_s8        (q_s8),
		.ovf_s8      (ovf_s8),
		.invert      (invert_q),
		.trim_offset (trim_q),
		.vld_s10     (vld_s10),
		.res_s10     (res_s10)
	);

	// s11..s17: expo blend; weight 0 reduces to the identity
	stc_expo u_expo (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.vld_s10      (vld_s10),
		.res_s10      (res_s10),
		.expo_percent (expo_q),
		.vld_s17      (vld_s17),
		.val_s17      (val_s17)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (out_ready)
				skid_vld_q <= 1'b0;
		end else if (vld_s17 && !out_ready) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_vld_q && vld_s17 && !out_ready)
			skid_q <= val_s17;
	end

	// slot first, it always holds the older word
	assign out_valid     = skid_vld_q || vld_s17;
	assign channel_value = skid_vld_q ? skid_q : val_s17;

	// every word handed out lies in the channel range
	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (channel_value >= CH_LOW && channel_value <= CH_HIGH))
		else $error("channel word out of range");

	// the slot only fills from a stalled last stage
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_vld_q) |-> $past(vld_s17 && !out_ready))
		else $error("skid slot filled without a stall");

	// a full slot freezes the last stage
	a_skid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_vld_q && vld_s17) |=> (vld_s17 && $stable(val_s17)))
		else $error("last stage moved while skid slot full");

endmodule
